### hw/rtl/vertex_dedup_indexer_macros.svh
// Assertion macros for the vertex dedup indexer.
`ifndef VERTEX_DEDUP_INDEXER_MACROS_SVH
`define VERTEX_DEDUP_INDEXER_MACROS_SVH

`ifndef ASSERT_OFF

`define VDI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vertex_dedup_indexer: assertion failed");

`define VDI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vertex_dedup_indexer: assertion failed");

`else

`define VDI_ASSERT_IMP(lbl, ante, cons)

`define VDI_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### hw/rtl/vdi_pkg.sv
// Shared types, constants and float compare helpers for the vertex dedup indexer.
`timescale 1ns / 1ps

package vdi_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int COORD_W     = 32;

  // x sits in the low bits, matching the packing of in_tdata
  typedef struct packed {
    logic [COORD_W-1:0] v;
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } vertex_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } tbl_req_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  function automatic logic is_nan(input logic [COORD_W-1:0] b);
    return b[COORD_W-2:0] > 31'h7F80_0000;
  endfunction

  // float equality: signed zeros match, NaN matches nothing
  function automatic logic feq(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
    logic zeros;
    zeros = ((a[COORD_W-2:0] | b[COORD_W-2:0]) == '0);
    return !is_nan(a) && !is_nan(b) && ((a == b) || zeros);
  endfunction

endpackage

### hw/rtl/vertex_dedup_indexer.sv
// A taken request is scanned entry by entry in S_SCAN; a hit, or the end of the stored entries,
// moves to S_OUT, which loads the result into the output register once that register is free.
// One table entry is read and compared per cycle through the single read port.
// in_tready is high only while idle: a new request is not taken until the last one has left S_OUT;
// a finished result may wait in the output register.
// Reset (rst_n low, synchronous) empties the table and sets textures_present to 1.
`timescale 1ns / 1ps

module vertex_dedup_indexer (
  input  logic         clk,
  input  logic         rst_n,
  // configuration: textures_present
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  // corner requests
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [159:0] in_tdata,  // pos_x, pos_y, pos_z, tex_u, tex_v (from bit 0 up)
  input  logic         in_tlast,  // last_corner
  // results
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata  // vertex_index[7:0], is_new[8], table_full[9], zero pad
);

  `include "vertex_dedup_indexer_macros.svh"

  localparam int IDX_W = vdi_pkg::IDX_W;
  localparam int CNT_W = vdi_pkg::CNT_W;

  vdi_pkg::state_t   state_r, state_nxt;
  vdi_pkg::vertex_t  key_r, key_nxt;
  vdi_pkg::vertex_t  in_vtx;
  vdi_pkg::vertex_t  rd_data;
  vdi_pkg::tbl_req_t req;

  logic             tex_r, tex_nxt;
  logic             last_r, last_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             cmp_valid_r, cmp_valid_nxt;
  logic [IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic             res_new_r, res_new_nxt;
  logic             res_full_r, res_full_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic             out_new_r, out_new_nxt;
  logic             out_full_r, out_full_nxt;
  logic             match;
  logic             commit;

  vdi_vertex_table u_table (
    .clk     (clk),
    .req     (req),
    .wr_data (key_r),
    .rd_data (rd_data)
  );

  vdi_match_unit u_match (
    .key   (key_r),
    .entry (rd_data),
    .match (match)
  );

  assign in_vtx     = vdi_pkg::vertex_t'(in_tdata);
  assign in_tready  = (state_r == vdi_pkg::S_IDLE);
  assign commit     = (state_r == vdi_pkg::S_OUT) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_full_r, out_new_r, out_idx_r};

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    tex_nxt       = tex_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_valid_nxt = cmp_valid_r;
    res_idx_nxt   = res_idx_r;
    res_new_nxt   = res_new_r;
    res_full_nxt  = res_full_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_new_nxt   = out_new_r;
    out_full_nxt  = out_full_r;
    req.wr_en     = 1'b0;
    req.wr_addr   = cnt_r[IDX_W-1:0];
    req.rd_en     = 1'b0;
    req.rd_addr   = scan_idx_r[IDX_W-1:0];

    if (cfg_wr_en) begin
      tex_nxt = cfg_wr_data;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      vdi_pkg::S_IDLE: begin
        if (in_tvalid) begin
          key_nxt = in_vtx;
          if (!tex_r) begin
            key_nxt.u = '0;
            key_nxt.v = '0;
          end
          last_nxt      = in_tlast;
          scan_idx_nxt  = '0;
          cmp_valid_nxt = 1'b0;
          state_nxt     = vdi_pkg::S_SCAN;
        end
      end
      vdi_pkg::S_SCAN: begin
        // read entry k while comparing entry k-1
        if (cmp_valid_r && match) begin
          res_idx_nxt   = cmp_idx_r;
          res_new_nxt   = 1'b0;
          res_full_nxt  = 1'b0;
          cmp_valid_nxt = 1'b0;
          state_nxt     = vdi_pkg::S_OUT;
        end else if (scan_idx_r < cnt_r) begin
          req.rd_en     = 1'b1;
          cmp_idx_nxt   = scan_idx_r[IDX_W-1:0];
          cmp_valid_nxt = 1'b1;
          scan_idx_nxt  = scan_idx_r + CNT_W'(1);
        end else begin
          cmp_valid_nxt = 1'b0;
          state_nxt     = vdi_pkg::S_OUT;
          if (cnt_r < CNT_W'(vdi_pkg::TABLE_DEPTH)) begin
            res_idx_nxt  = cnt_r[IDX_W-1:0];
            res_new_nxt  = 1'b1;
            res_full_nxt = 1'b0;
          end else begin
            res_idx_nxt  = '0;
            res_new_nxt  = 1'b0;
            res_full_nxt = 1'b1;
          end
        end
      end
      vdi_pkg::S_OUT: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = res_idx_r;
          out_new_nxt   = res_new_r;
          out_full_nxt  = res_full_r;
          if (res_new_r) begin
            req.wr_en = 1'b1;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end
          if (last_r) begin
            cnt_nxt = '0;
          end
          state_nxt = vdi_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = vdi_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vdi_pkg::S_IDLE;
      tex_r       <= 1'b1;
      cnt_r       <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tex_r       <= tex_nxt;
      cnt_r       <= cnt_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    last_r     <= last_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    res_idx_r  <= res_idx_nxt;
    res_new_r  <= res_new_nxt;
    res_full_r <= res_full_nxt;
    out_idx_r  <= out_idx_nxt;
    out_new_r  <= out_new_nxt;
    out_full_r <= out_full_nxt;
  end

  `VDI_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(vdi_pkg::TABLE_DEPTH))
  `VDI_ASSERT_IMP(a_full_at_cap, commit && res_full_r, cnt_r == CNT_W'(vdi_pkg::TABLE_DEPTH))
  `VDI_ASSERT_IMP(a_new_xor_full, out_valid_r, !(out_new_r && out_full_r))
  `VDI_ASSERT_NXT(a_append_grows, commit && res_new_r && !last_r, cnt_r == $past(cnt_r) + CNT_W'(1))
  `VDI_ASSERT_NXT(a_last_empties, commit && last_r, cnt_r == '0)

endmodule

### hw/rtl/vdi_vertex_table.sv
// Unique-vertex storage: one write port, one registered read port.
`timescale 1ns / 1ps

module vdi_vertex_table (
  input  logic             clk,
  input  vdi_pkg::tbl_req_t req,
  input  vdi_pkg::vertex_t  wr_data,
  output vdi_pkg::vertex_t  rd_data
);

  vdi_pkg::vertex_t mem [vdi_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

### hw/rtl/vdi_match_unit.sv
// Shared compare unit: float equality of all five coordinates.
`timescale 1ns / 1ps

module vdi_match_unit (
  input  vdi_pkg::vertex_t key,
  input  vdi_pkg::vertex_t entry,
  output logic             match
);

  assign match = vdi_pkg::feq(key.x, entry.x) && vdi_pkg::feq(key.y, entry.y) &&
                 vdi_pkg::feq(key.z, entry.z) && vdi_pkg::feq(key.u, entry.u) &&
                 vdi_pkg::feq(key.v, entry.v);

endmodule

### dv/vertex_dedup_indexer_checker.sv
// Checker for the vertex dedup indexer: predicts each corner's index and compares results.
`timescale 1ns / 1ps

module vertex_dedup_indexer_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [159:0] in_tdata,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [15:0]  out_tdata,
  output int           fail_count,
  output int           awaited_count
);

  typedef struct packed {
    logic [7:0] idx;
    logic       is_new;
    logic       full;
  } corner_result_t;

  vdi_pkg::vertex_t mesh_table [vdi_pkg::TABLE_DEPTH];
  int               mesh_entries;
  logic             textures_on;
  corner_result_t   awaited_results [$];

  function automatic logic coord_is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  // float compare: signed zeros alias, NaN never equal
  function automatic logic coord_equal(input logic [31:0] a, input logic [31:0] b);
    if (coord_is_nan(a) || coord_is_nan(b)) return 1'b0;
    return (a == b) || ((a[30:0] | b[30:0]) == 31'd0);
  endfunction

  function automatic logic same_vertex(input vdi_pkg::vertex_t a, input vdi_pkg::vertex_t b);
    return coord_equal(a.x, b.x) && coord_equal(a.y, b.y) && coord_equal(a.z, b.z) &&
           coord_equal(a.u, b.u) && coord_equal(a.v, b.v);
  endfunction

  // searches the mesh table in insertion order, appends on a miss while there is room
  function automatic corner_result_t index_corner(input vdi_pkg::vertex_t c, input logic last);
    corner_result_t r;
    logic           found;
    int             k;
    r = '0;
    found = 1'b0;
    if (!textures_on) begin
      c.u = '0;
      c.v = '0;
    end
    for (k = 0; k < mesh_entries; k++) begin
      if (!found && same_vertex(c, mesh_table[k])) begin
        found = 1'b1;
        r.idx = k[7:0];
      end
    end
    if (!found) begin
      if (mesh_entries < vdi_pkg::TABLE_DEPTH) begin
        mesh_table[mesh_entries] = c;
        r.idx = mesh_entries[7:0];
        r.is_new = 1'b1;
        mesh_entries++;
      end else begin
        r.full = 1'b1;
      end
    end
    if (last) mesh_entries = 0;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    corner_result_t   want;
    vdi_pkg::vertex_t corner;
    if (!rst_n) begin
      mesh_entries = 0;
      textures_on = 1'b1;
      awaited_results.delete();
      fail_count = 0;
      awaited_count = 0;
    end else begin
      if (cfg_wr_en) textures_on = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          fail_count++;
          $error("result with no request waiting: out_tdata %h", out_tdata);
        end else begin
          want = awaited_results.pop_front();
          if (out_tdata[7:0] !== want.idx) begin
            fail_count++;
            $error("vertex_index: expected %0d, got %0d", want.idx, out_tdata[7:0]);
          end
          if (out_tdata[8] !== want.is_new) begin
            fail_count++;
            $error("is_new: expected %0b, got %0b", want.is_new, out_tdata[8]);
          end
          if (out_tdata[9] !== want.full) begin
            fail_count++;
            $error("table_full: expected %0b, got %0b", want.full, out_tdata[9]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        corner = in_tdata;
        awaited_results.insert(awaited_results.size(), index_corner(corner, in_tlast));
      end
      awaited_count = awaited_results.size();
    end
  end

endmodule

### dv/vertex_dedup_indexer_test.sv
// Top of the vertex dedup indexer testbench: clock, reset, corner stimulus and verdict.
`timescale 1ns / 1ps

module vertex_dedup_indexer_test;

  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int PHASE_ITEMS  = 467;
  localparam int BIG_MESH     = 300;

  localparam logic [31:0] F_POS_ZERO = 32'h0000_0000;
  localparam logic [31:0] F_NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] F_ONE      = 32'h3F80_0000;
  localparam logic [31:0] F_TWO      = 32'h4000_0000;
  localparam logic [31:0] F_THREE    = 32'h4040_0000;
  localparam logic [31:0] F_HALF     = 32'h3F00_0000;
  localparam logic [31:0] F_QUARTER  = 32'h3E80_0000;
  localparam logic [31:0] F_QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] F_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] F_POS_INF  = 32'h7F80_0000;
  localparam logic [31:0] F_NEG_INF  = 32'hFF80_0000;
  localparam logic [31:0] F_MAX      = 32'h7F7F_FFFF;
  localparam logic [31:0] F_TINY     = 32'h0000_0001;
  localparam logic [31:0] F_NEG_TINY = 32'h8000_0001;

  logic         clk;
  logic         rst_n;
  logic         cfg_wr_en;
  logic         cfg_wr_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [159:0] in_tdata;  // pos_x, pos_y, pos_z, tex_u, tex_v (from bit 0 up)
  logic         in_tlast;  // last_corner
  logic         out_tvalid;
  logic         out_tready;
  logic [15:0]  out_tdata; // vertex_index[7:0], is_new[8], table_full[9], zero pad

  int fail_count;
  int awaited_count;
  int cycle_count;
  int sender_idle_pct;
  int receiver_idle_pct;
  int corners_sent;
  int meshes_sent;

  vertex_dedup_indexer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  vertex_dedup_indexer_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .awaited_count(awaited_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("vertex_dedup_indexer_test failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= receiver_idle_pct);
  end

  function automatic vdi_pkg::vertex_t make_corner(input logic [31:0] x, input logic [31:0] y,
                                                   input logic [31:0] z, input logic [31:0] u,
                                                   input logic [31:0] v);
    vdi_pkg::vertex_t c;
    c.x = x;
    c.y = y;
    c.z = z;
    c.u = u;
    c.v = v;
    return c;
  endfunction

  // mix of raw patterns and float special values so partial matches happen
  function automatic logic [31:0] rand_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 11))
      0: r = F_POS_ZERO;
      1: r = F_NEG_ZERO;
      2: begin
        r[30:23] = 8'hFF;
        if (r[22:0] == 23'd0) r[0] = 1'b1;
      end
      3: r[30:0] = F_POS_INF[30:0];
      4: r[30:23] = 8'h00;
      5, 6: begin
        case ($urandom_range(0, 3))
          0: r = F_ONE;
          1: r = F_ONE | F_NEG_ZERO;
          2: r = F_TWO;
          default: r = F_HALF;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_corner(input vdi_pkg::vertex_t c, input logic last);
    @(negedge clk);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = c;
    in_tlast = last;
    do @(posedge clk); while (!in_tready);
    corners_sent++;
    if (last) meshes_sent++;
  endtask

  // holds off new requests until every result is back
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (awaited_count != 0) @(negedge clk);
  endtask

  task automatic write_textures(input logic on);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = on;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic send_mesh(input int corners, input int reuse_pct);
    vdi_pkg::vertex_t mesh_corners [$];
    vdi_pkg::vertex_t c;
    int               i;
    for (i = 0; i < corners; i++) begin
      if (mesh_corners.size() != 0 && $urandom_range(99) < reuse_pct) begin
        c = mesh_corners[$urandom_range(mesh_corners.size() - 1)];
        case ($urandom_range(0, 5))
          0: if (c.x[30:0] == 31'd0) c.x[31] = ~c.x[31];  // other zero sign
          1: begin
            c.u = $urandom;
            c.v = $urandom;
          end
          2: c.z = rand_coord();
          default: ;
        endcase
      end else begin
        c = make_corner(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end
      mesh_corners.insert(mesh_corners.size(), c);
      send_corner(c, i == corners - 1);
    end
  endtask

  initial begin
    int phase;
    int phase_start;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cycle_count = 0;
    corners_sent = 0;
    meshes_sent = 0;
    sender_idle_pct = 26;
    receiver_idle_pct = 82;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    write_textures(1'b1);

    // directed: hits, signed zeros, NaN, extremes, last corner
    send_corner(make_corner(F_ONE, F_TWO, F_THREE, F_HALF, F_QUARTER), 1'b0);
    send_corner(make_corner(F_ONE, F_TWO, F_THREE, F_HALF, F_QUARTER), 1'b0);
    send_corner(make_corner(F_POS_ZERO, F_NEG_ZERO, F_POS_ZERO, F_HALF, F_HALF), 1'b0);
    send_corner(make_corner(F_NEG_ZERO, F_POS_ZERO, F_NEG_ZERO, F_HALF, F_HALF), 1'b0);
    send_corner(make_corner(F_QNAN, F_ONE, F_ONE, F_ONE, F_ONE), 1'b0);
    send_corner(make_corner(F_QNAN, F_ONE, F_ONE, F_ONE, F_ONE), 1'b0);
    send_corner(make_corner(F_ALL_ONES, F_ALL_ONES, F_ALL_ONES, F_ALL_ONES, F_ALL_ONES), 1'b0);
    send_corner(make_corner(F_ONE, F_TWO, F_THREE, F_TWO, F_QUARTER), 1'b0);
    send_corner(make_corner(F_POS_INF, F_NEG_INF, F_TINY, F_MAX, F_NEG_TINY), 1'b0);
    send_corner(make_corner(F_POS_INF, F_NEG_INF, F_TINY, F_MAX, F_NEG_TINY), 1'b1);
    send_corner(make_corner(F_ONE, F_TWO, F_THREE, F_HALF, F_QUARTER), 1'b0);
    wait_drained();
    write_textures(1'b0);
    // texture coordinates ignored until textures are turned back on
    send_corner(make_corner(F_ONE, F_TWO, F_THREE, F_HALF, F_QUARTER), 1'b0);
    send_corner(make_corner(F_ONE, F_TWO, F_THREE, F_QNAN, F_MAX), 1'b0);
    send_corner(make_corner(F_POS_ZERO, F_POS_ZERO, F_POS_ZERO, F_ALL_ONES, F_ALL_ONES), 1'b0);
    send_corner(make_corner(F_NEG_ZERO, F_POS_ZERO, F_POS_ZERO, F_ONE, F_TWO), 1'b1);
    wait_drained();
    write_textures(1'b1);
    send_corner(make_corner(F_POS_ZERO, F_POS_ZERO, F_POS_ZERO, F_POS_ZERO, F_POS_ZERO), 1'b1);

    for (phase = 0; phase < 3; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          sender_idle_pct = 26;
          receiver_idle_pct = 82;
        end
        1: begin
          sender_idle_pct = 82;
          receiver_idle_pct = 26;
        end
        default: begin
          sender_idle_pct = 0;
          receiver_idle_pct = 0;
        end
      endcase
      write_textures(phase != 1);
      phase_start = corners_sent;
      if (phase != 1) begin
        // enough distinct corners to overflow the table
        send_mesh(BIG_MESH, 8);
        if (phase == 2) begin
          wait_drained();
          write_textures(1'b0);
        end
      end
      while (corners_sent - phase_start < PHASE_ITEMS) begin
        send_mesh($urandom_range(1, 40), 45);
        if ($urandom_range(0, 5) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (300) @(negedge clk);
    $display("Sent %0d corners in %0d meshes, with textures on and off,", corners_sent,
             meshes_sent);
    $display("under three pacing modes, including table overflow and float special values.");
    if (fail_count == 0 && awaited_count == 0) begin
      $display("vertex_dedup_indexer_test passed");
    end else begin
      $display("vertex_dedup_indexer_test failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/vdi_pkg.sv
hw/rtl/vdi_vertex_table.sv
hw/rtl/vdi_match_unit.sv
hw/rtl/vertex_dedup_indexer.sv
dv/vertex_dedup_indexer_checker.sv
dv/vertex_dedup_indexer_test.sv
